>>> sv/smn_pkg.sv
// Package: shared constants, types and helper functions for the surface metric block.
`default_nettype none
package smn_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NORM_FRAC = 30;
    localparam int QDEPTH = 4;

    // Front-to-back queue entry: clamped tangents of one quadrature point.
    typedef struct packed {
        logic signed [31:0] au0, au1, au2;
        logic signed [31:0] bv0, bv1, bv2;
    } t_tan;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction
endpackage
`default_nettype wire

>>> sv/smn_front.sv
// Front end: sums tangents one term per cycle unless full; queues clamped tangents.
`default_nettype none
module smn_front #(
    parameter int FRAC_BITS = smn_pkg::FRAC_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire signed [31:0]   i_du,
    input  wire signed [31:0]   i_dv,
    input  wire signed [31:0]   i_cx,
    input  wire signed [31:0]   i_cy,
    input  wire signed [31:0]   i_cz,
    input  wire                 i_last,
    output logic                o_q_valid,
    input  wire                 i_q_ready,
    output smn_pkg::t_tan       o_q_data
);
    localparam int QW = $clog2(smn_pkg::QDEPTH);
    logic signed [63:0] r_su [3];
    logic signed [63:0] r_sv [3];
    logic signed [63:0] n_su [3];
    logic signed [63:0] n_sv [3];
    smn_pkg::t_tan r_q [smn_pkg::QDEPTH];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0]   r_cnt;
    logic          acc, push, pop;
    logic signed [31:0] c [3];
    logic signed [63:0] prod_u, prod_v;
    smn_pkg::t_tan ent;

    assign c[0] = i_cx;
    assign c[1] = i_cy;
    assign c[2] = i_cz;
    assign o_ready = (r_cnt != QW'(0) + (QW+1)'(smn_pkg::QDEPTH));
    assign acc  = i_valid && o_ready;
    assign push = acc && i_last;
    assign o_q_valid = (r_cnt != '0);
    assign pop  = o_q_valid && i_q_ready;
    assign o_q_data = r_q[r_rp];

    always_comb begin
        prod_u = '0;
        prod_v = '0;
        for (int k = 0; k < 3; k++) begin
            prod_u = i_du * c[k];
            prod_v = i_dv * c[k];
            n_su[k] = smn_pkg::sat_add64(r_su[k], prod_u >>> FRAC_BITS);
            n_sv[k] = smn_pkg::sat_add64(r_sv[k], prod_v >>> FRAC_BITS);
        end
        ent.au0 = smn_pkg::clamp32(n_su[0]);
        ent.au1 = smn_pkg::clamp32(n_su[1]);
        ent.au2 = smn_pkg::clamp32(n_su[2]);
        ent.bv0 = smn_pkg::clamp32(n_sv[0]);
        ent.bv1 = smn_pkg::clamp32(n_sv[1]);
        ent.bv2 = smn_pkg::clamp32(n_sv[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_su[k] <= '0;
                r_sv[k] <= '0;
            end
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (acc) begin
                for (int k = 0; k < 3; k++) begin
                    r_su[k] <= i_last ? 64'sd0 : n_su[k];
                    r_sv[k] <= i_last ? 64'sd0 : n_sv[k];
                end
            end
            if (push) begin
                r_q[r_wp] <= ent;
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QW+1)'(push) - (QW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

>>> sv/smn_back.sv
// Back end: metric, iterative square root and shared serial divider per point.
`default_nettype none
module smn_back #(
    parameter int FRAC_BITS = smn_pkg::FRAC_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire [30:0]          i_min_area,
    input  wire                 i_q_valid,
    output logic                o_q_ready,
    input  smn_pkg::t_tan       i_q_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [317:0]        o_data
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_M1 = 8'b00000010, S_M2 = 8'b00000100,
        S_DET  = 8'b00001000, S_SQRT = 8'b00010000, S_DSET = 8'b00100000,
        S_DIV  = 8'b01000000, S_OUT = 8'b10000000
    } t_state;
    t_state r_st;
    logic signed [31:0] r_a [3];
    logic signed [31:0] r_b [3];
    logic signed [63:0] r_p [3];
    logic [1:0]  r_ph;
    logic [65:0] r_acc11, r_acc22;
    logic signed [65:0] r_acc12;
    logic [30:0] r_g11, r_g22;
    logic signed [31:0] r_g12;
    logic [63:0] r_det, r_x, r_res, r_bit;
    logic [5:0]  r_sc;
    logic [30:0] r_area;
    logic        r_degen;
    logic [2:0]  r_di;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic        r_neg;
    logic [64:0] r_rem;
    logic [31:0] r_quo;
    logic [6:0]  r_dc, r_dtot;
    logic        r_sat;
    logic signed [31:0] r_o [6];
    logic [64:0] rsh, rsub;
    logic [32:0] qsh;
    logic signed [63:0] m0, m1, m2;

    assign o_q_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_data = {r_degen, r_o[5], r_o[4], r_o[3], r_area, r_o[2], r_o[1], r_o[0],
                     r_g22, r_g12, r_g11};

    always_comb begin
        rsh  = {r_rem[63:0], (r_dc < 7'd64) ? r_num[6'(7'd63 - r_dc)] : 1'b0};
        rsub = rsh - {1'b0, r_den};
        qsh  = {r_quo, !rsub[64]};
        m0 = (r_ph == 2'd0) ? r_a[0] * r_a[0] : (r_ph == 2'd1) ? r_b[0] * r_b[0] : r_a[0] * r_b[0];
        m1 = (r_ph == 2'd0) ? r_a[1] * r_a[1] : (r_ph == 2'd1) ? r_b[1] * r_b[1] : r_a[1] * r_b[1];
        m2 = (r_ph == 2'd0) ? r_a[2] * r_a[2] : (r_ph == 2'd1) ? r_b[2] * r_b[2] : r_a[2] * r_b[2];
    end

    // Loads dividend magnitude, sign, denominator and extra bits for one quotient.
    task automatic load_div(input logic [2:0] k);
        logic signed [64:0] d;
        logic signed [63:0] p1, p2;
        case (k)
            3'd0: begin r_num <= 64'(r_g22); r_neg <= 1'b0; end
            3'd1: begin
                r_num <= 64'(r_g12 < 0 ? -33'(r_g12) : 33'(r_g12));
                r_neg <= (r_g12 > 0);
            end
            3'd2: begin r_num <= 64'(r_g11); r_neg <= 1'b0; end
            default: begin
                case (k)
                    3'd3: begin p1 = r_a[1] * r_b[2]; p2 = r_a[2] * r_b[1]; end
                    3'd4: begin p1 = r_a[2] * r_b[0]; p2 = r_a[0] * r_b[2]; end
                    default: begin p1 = r_a[0] * r_b[1]; p2 = r_a[1] * r_b[0]; end
                endcase
                d = 65'(p1) - 65'(p2);
                r_neg <= d[64];
                r_num <= d[64] ? 64'(-d) : d[63:0];
            end
        endcase
        r_den  <= (k < 3'd3) ? r_det : 64'(r_area);
        r_dtot <= (k < 3'd3) ? 7'(64 + 2 * FRAC_BITS) : 7'(64 + smn_pkg::NORM_FRAC - FRAC_BITS);
        r_rem <= '0;
        r_quo <= '0;
        r_dc  <= '0;
        r_sat <= 1'b0;
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_a[0] <= i_q_data.au0; r_a[1] <= i_q_data.au1; r_a[2] <= i_q_data.au2;
                    r_b[0] <= i_q_data.bv0; r_b[1] <= i_q_data.bv1; r_b[2] <= i_q_data.bv2;
                    r_ph <= 2'd0;
                    r_st <= S_M1;
                end
                S_M1: begin
                    r_p[0] <= m0; r_p[1] <= m1; r_p[2] <= m2;
                    r_st <= S_M2;
                end
                S_M2: begin
                    case (r_ph)
                        2'd0: r_acc11 <= 66'(r_p[0]) + 66'(r_p[1]) + 66'(r_p[2]);
                        2'd1: r_acc22 <= 66'(r_p[0]) + 66'(r_p[1]) + 66'(r_p[2]);
                        default: r_acc12 <= 66'(r_p[0]) + 66'(r_p[1]) + 66'(r_p[2]);
                    endcase
                    if (r_ph == 2'd2) begin
                        r_st <= S_DET;
                        r_ph <= 2'd0;
                    end else begin
                        r_ph <= r_ph + 2'd1;
                        r_st <= S_M1;
                    end
                end
                S_DET: begin
                    if (r_ph == 2'd0) begin
                        r_g11 <= ((r_acc11 >> FRAC_BITS) > 66'h7FFFFFFF) ? 31'h7FFFFFFF
                                 : 31'(r_acc11 >> FRAC_BITS);
                        r_g22 <= ((r_acc22 >> FRAC_BITS) > 66'h7FFFFFFF) ? 31'h7FFFFFFF
                                 : 31'(r_acc22 >> FRAC_BITS);
                        r_g12 <= smn_pkg::clamp32(64'(r_acc12 >>> FRAC_BITS));
                        r_ph <= 2'd1;
                    end else if (r_ph == 2'd1) begin
                        r_p[0] <= 64'(r_g11) * 64'(r_g22);
                        r_p[1] <= r_g12 * r_g12;
                        r_ph <= 2'd2;
                    end else begin
                        r_det <= (r_p[0] < r_p[1]) ? 64'd0 : 64'(r_p[0] - r_p[1]);
                        r_x   <= (r_p[0] < r_p[1]) ? 64'd0 : 64'(r_p[0] - r_p[1]);
                        r_res <= '0;
                        r_bit <= 64'd1 << 62;
                        r_sc  <= '0;
                        r_st  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_x >= r_res + r_bit) begin
                        r_x <= r_x - (r_res + r_bit);
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_sc <= r_sc + 6'd1;
                    if (r_sc == 6'd31) begin
                        r_st <= S_DSET;
                    end
                end
                S_DSET: begin
                    r_area  <= r_res[30:0];
                    r_degen <= (r_res[30:0] <= i_min_area);
                    if (r_res[30:0] <= i_min_area) begin
                        for (int k = 0; k < 6; k++) r_o[k] <= '0;
                        r_o[5] <= 32'sd1 <<< smn_pkg::NORM_FRAC;
                        r_st <= S_OUT;
                    end else begin
                        r_di <= 3'd0;
                        load_div(3'd0);
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_dc == r_dtot || r_sat) begin
                        r_o[r_di] <= r_sat ? (r_neg ? -32'sh7FFFFFFF : 32'sh7FFFFFFF)
                                   : (r_neg ? -$signed(r_quo) : $signed(r_quo));
                        if (r_di == 3'd5) begin
                            r_st <= S_OUT;
                        end else begin
                            r_di <= r_di + 3'd1;
                            load_div(r_di + 3'd1);
                        end
                    end else begin
                        r_rem <= rsub[64] ? rsh : rsub;
                        r_quo <= qsh[31:0];
                        r_sat <= (qsh > 33'h7FFFFFFF);
                        r_dc  <= r_dc + 7'd1;
                    end
                end
                S_OUT: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/surface_metric_and_normal.sv
// Top level: surface first fundamental form, inverse metric, area element and unit normal.
//
// Input beats on s_axis carry one basis term each; while the queue has room, the
// front end folds one term into the u and v tangent sums per cycle. The beat with
// tlast closes a quadrature point: its clamped tangents enter a four-entry queue and
// the sums clear. The back end takes one point at a time: metric products, 32 square
// root steps, then six serial divisions one quotient bit per cycle (96 bits for the
// inverse metric, 78 for the normal, earlier on saturation) on the shared divider.
// A degenerate point skips the division. Terms are accepted one per cycle while the
// queue has room, also while a result waits. The result is held on m_axis until
// m_axis_tready; then the next point starts. Reset clears the sums, the queue and the
// back end, and sets the threshold to one. The user must write the threshold through
// i_cfg_we / i_cfg_data only while the block is idle; the block does not enforce it.
`default_nettype none
module surface_metric_and_normal #(
    parameter int FRAC_BITS = smn_pkg::FRAC_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire [30:0]   i_cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // deriv_u, deriv_v, ctrl_x, ctrl_y, ctrl_z
    input  wire [159:0]  s_axis_tdata,
    input  wire          s_axis_tlast,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // metric_11, metric_12, metric_22, inv_metric_11, inv_metric_12, inv_metric_22,
    // area_element, normal_x, normal_y, normal_z, degenerate, zero pad
    output logic [319:0] m_axis_tdata
);
    logic [30:0] r_min_area;
    logic q_valid, q_ready;
    smn_pkg::t_tan q_data;
    logic [317:0] res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_area <= 31'd1;
        end else if (i_cfg_we) begin
            r_min_area <= i_cfg_data;
        end
    end

    smn_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_du(s_axis_tdata[31:0]), .i_dv(s_axis_tdata[63:32]),
        .i_cx(s_axis_tdata[95:64]), .i_cy(s_axis_tdata[127:96]),
        .i_cz(s_axis_tdata[159:128]), .i_last(s_axis_tlast),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_data(q_data)
    );

    smn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_min_area(r_min_area),
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_data(q_data),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(res)
    );

    assign m_axis_tdata = {2'b00, res};

    // A degenerate result always carries the fallback normal.
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[317]) |-> (m_axis_tdata[316:285] == 32'h40000000))
        else $error("degenerate result without fallback normal");
    // A stalled result holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
endmodule
`default_nettype wire
